### design/bca_pkg.sv
// Shared types and constants for the bitmap cluster allocator.
// Depends on nothing; every design file imports it.
package bca_pkg;

   // Default sizing of the bitmap store.
   localparam int unsigned CLUSTERS_DEF  = 65536;
   localparam int unsigned WORD_BITS_DEF = 64;

   // Field widths fixed by the interface.
   localparam int unsigned LIMIT_W = 17;
   localparam int unsigned IDX_W   = LIMIT_W;       // cluster - 1 fits here
   localparam int unsigned DIV_K   = IDX_W + 7;     // reciprocal precision, WORD_BITS <= 64

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd65536;

   localparam logic ACT_FIND = 1'b0;
   localparam logic ACT_MARK = 1'b1;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_NONE  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      logic               action;
      logic [LIMIT_W-1:0] cluster;
      logic               used;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [LIMIT_W-1:0] found_cluster;
   } rsp_type;

endpackage

### design/bca_word_scan.sv
// Free-bit search over one bitmap word: lowest clear bit among the low bits in range.
// Depends on bca_pkg.
module bca_word_scan #(
   parameter int unsigned WORD_BITS = bca_pkg::WORD_BITS_DEF
) (
   input  logic [WORD_BITS-1:0]                word,
   input  logic [$clog2(WORD_BITS + 1)-1:0]    count,
   output logic                                hit,
   output logic [$clog2(WORD_BITS)-1:0]        pos
);
   import bca_pkg::*;

   localparam int unsigned CNT_W = $clog2(WORD_BITS + 1);
   localparam int unsigned POS_W = $clog2(WORD_BITS);

   logic [WORD_BITS-1:0] avail;

   // only bits below count belong to clusters inside the limit
   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         avail[b] = ~word[b] && (CNT_W'(b) < count);
      end
   end

   // priority encoder, lowest set bit wins
   always_comb begin
      pos = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (avail[b]) begin
            pos = POS_W'(b);
         end
      end
   end

   assign hit = |avail;

endmodule

### design/bitmap_cluster_allocator.sv
// Bitmap cluster allocator, top level: request decode, bitmap memory, scan and
// read-modify-write sequencer. Depends on bca_pkg and bca_word_scan.
//
// The allocator holds one bit per cluster (set = used) in a single-port-write,
// registered-read memory of WORD_BITS-bit words, ceil(CLUSTERS/WORD_BITS) deep.
// After reset a clearing pass writes every word to zero, one word per cycle;
// req_stall stays high through it, while csr writes are taken as usual. The
// block works on one transaction at a time. A find reads the bitmap one word
// per cycle from word 0 and stops at the first word with a free cluster inside
// the limit. A mark goes through two steps of reciprocal multiply to split the
// cluster into word and bit, one read, one write, one to hand over the result.
// A cluster of 0 or above the limit gets status ST_RANGE and touches nothing.
// A finished result sits in an output register, so the next transaction is
// accepted while the previous result is still stalled. The limit written
// through csr_wdata is clipped to CLUSTERS; write it only while no transaction
// is in flight.
module bitmap_cluster_allocator #(
   parameter int unsigned CLUSTERS  = bca_pkg::CLUSTERS_DEF,
   parameter int unsigned WORD_BITS = bca_pkg::WORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  bca_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output bca_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic [bca_pkg::LIMIT_W-1:0]   csr_wdata
);
   import bca_pkg::*;

   localparam int unsigned DEPTH  = (CLUSTERS + WORD_BITS - 1) / WORD_BITS;
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W  = $clog2(WORD_BITS + 1);
   localparam int unsigned POS_W  = $clog2(WORD_BITS);
   localparam int unsigned PROD_W = IDX_W + DIV_K;
   localparam logic [DIV_K-1:0] RECIP = DIV_K'((64'(1) << DIV_K) / WORD_BITS);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_CLEAR  = 8'b0000_0010,
      S_FIND   = 8'b0000_0100,
      S_MK_MUL = 8'b0000_1000,
      S_MK_DIV = 8'b0001_0000,
      S_MK_RD  = 8'b0010_0000,
      S_MK_WR  = 8'b0100_0000,
      S_RESP   = 8'b1000_0000
   } state_type;

   // control registers
   state_type            state_ff, state_in;
   logic [LIMIT_W-1:0]   limit_ff, limit_in;
   logic [ADDR_W-1:0]    clr_addr_ff, clr_addr_in;
   logic                 rd_valid_ff, rd_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [ADDR_W-1:0]    iss_addr_ff, iss_addr_in;
   logic [LIMIT_W-1:0]   iss_rem_ff, iss_rem_in;     // clusters left to read
   logic [LIMIT_W-1:0]   iss_base_ff, iss_base_in;   // cluster index of word start
   logic [LIMIT_W-1:0]   rd_base_ff, rd_base_in;
   logic [CNT_W-1:0]     rd_cnt_ff, rd_cnt_in;       // in-range bits of word in flight
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 used_ff, used_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [IDX_W-1:0]     q0_ff, q0_in;
   logic [IDX_W-1:0]     qw_ff, qw_in;
   logic [ADDR_W-1:0]    waddr_ff, waddr_in;
   logic [POS_W-1:0]     bit_ff, bit_in;
   rsp_type              res_ff, res_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   // bitmap memory
   logic [WORD_BITS-1:0] bitmap_mem [DEPTH];
   logic [WORD_BITS-1:0] mem_rdata_ff;
   logic                 mem_re;
   logic [ADDR_W-1:0]    mem_raddr;
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr;
   logic [WORD_BITS-1:0] mem_wdata;

   logic [LIMIT_W-1:0]   eff_limit;
   logic                 req_take;
   logic                 out_free;
   logic                 scan_hit;
   logic [POS_W-1:0]     scan_pos;
   logic [IDX_W-1:0]     rem0;
   logic [IDX_W-1:0]     q_fix;
   logic [IDX_W-1:0]     r_fix;

   // a limit above the store size acts as the store size
   assign eff_limit = (32'(limit_ff) > CLUSTERS) ? LIMIT_W'(CLUSTERS) : limit_ff;

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   bca_word_scan #(
      .WORD_BITS (WORD_BITS)
   ) u_scan (
      .word  (mem_rdata_ff),
      .count (rd_cnt_ff),
      .hit   (scan_hit),
      .pos   (scan_pos)
   );

   // quotient correction: the floor reciprocal undershoots by at most one
   always_comb begin
      rem0 = idx_ff - qw_ff;
      if (32'(rem0) >= WORD_BITS) begin
         q_fix = q0_ff + IDX_W'(1);
         r_fix = rem0 - IDX_W'(WORD_BITS);
      end else begin
         q_fix = q0_ff;
         r_fix = rem0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      limit_in     = limit_ff;
      clr_addr_in  = clr_addr_ff;
      rd_valid_in  = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      iss_addr_in  = iss_addr_ff;
      iss_rem_in   = iss_rem_ff;
      iss_base_in  = iss_base_ff;
      rd_base_in   = iss_base_ff;
      rd_cnt_in    = (32'(iss_rem_ff) > WORD_BITS) ? CNT_W'(WORD_BITS) : CNT_W'(iss_rem_ff);
      idx_in       = idx_ff;
      used_in      = used_ff;
      prod_in      = prod_ff;
      q0_in        = q0_ff;
      qw_in        = qw_ff;
      waddr_in     = waddr_ff;
      bit_in       = bit_ff;
      res_in       = res_ff;
      mem_re       = 1'b0;
      mem_raddr    = iss_addr_ff;
      mem_we       = 1'b0;
      mem_waddr    = waddr_ff;
      mem_wdata    = mem_rdata_ff;

      if (csr_we) begin
         limit_in = csr_wdata;
      end

      // output register drains independently of the sequencer
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
            mem_wdata = '0;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               if (req_data.action == ACT_FIND) begin
                  iss_addr_in = '0;
                  iss_base_in = '0;
                  iss_rem_in  = eff_limit;
                  state_in    = S_FIND;
               end else if (req_data.cluster == '0 || req_data.cluster > eff_limit) begin
                  res_in.status        = ST_RANGE;
                  res_in.found_cluster = '0;
                  state_in             = S_RESP;
               end else begin
                  idx_in   = IDX_W'(req_data.cluster - LIMIT_W'(1));
                  used_in  = req_data.used;
                  state_in = S_MK_MUL;
               end
            end
         end
         S_FIND: begin
            // issue side: one word per cycle until the limit is covered
            if (iss_rem_ff != '0) begin
               mem_re      = 1'b1;
               rd_valid_in = 1'b1;
               iss_addr_in = iss_addr_ff + ADDR_W'(1);
               iss_base_in = iss_base_ff + LIMIT_W'(WORD_BITS);
               iss_rem_in  = (32'(iss_rem_ff) > WORD_BITS) ?
                             iss_rem_ff - LIMIT_W'(WORD_BITS) : '0;
            end
            // data side: word read last cycle
            if (rd_valid_ff && scan_hit) begin
               res_in.status        = ST_OK;
               res_in.found_cluster = rd_base_ff + LIMIT_W'(scan_pos) + LIMIT_W'(1);
               state_in             = S_RESP;
            end else if (!rd_valid_ff && iss_rem_ff == '0) begin
               res_in.status        = ST_NONE;
               res_in.found_cluster = '0;
               state_in             = S_RESP;
            end
         end
         S_MK_MUL: begin
            prod_in  = PROD_W'(idx_ff) * PROD_W'(RECIP);
            state_in = S_MK_DIV;
         end
         S_MK_DIV: begin
            q0_in    = prod_ff[PROD_W-1:DIV_K];
            qw_in    = IDX_W'(prod_ff[PROD_W-1:DIV_K] * IDX_W'(WORD_BITS));
            state_in = S_MK_RD;
         end
         S_MK_RD: begin
            mem_re    = 1'b1;
            mem_raddr = ADDR_W'(q_fix);
            waddr_in  = ADDR_W'(q_fix);
            bit_in    = POS_W'(r_fix);
            state_in  = S_MK_WR;
         end
         S_MK_WR: begin
            mem_we              = 1'b1;
            mem_wdata           = mem_rdata_ff;
            mem_wdata[bit_ff]   = used_ff;
            res_in.status        = ST_OK;
            res_in.found_cluster = '0;
            state_in             = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         limit_ff     <= LIMIT_RESET;
         clr_addr_ff  <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         clr_addr_ff  <= clr_addr_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      iss_addr_ff <= iss_addr_in;
      iss_rem_ff  <= iss_rem_in;
      iss_base_ff <= iss_base_in;
      rd_base_ff  <= rd_base_in;
      rd_cnt_ff   <= rd_cnt_in;
      idx_ff      <= idx_in;
      used_ff     <= used_in;
      prod_ff     <= prod_in;
      q0_ff       <= q0_in;
      qw_ff       <= qw_in;
      waddr_ff    <= waddr_in;
      bit_ff      <= bit_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // bitmap store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         bitmap_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= bitmap_mem[mem_raddr];
      end
   end

   // ---- assertions ----

   // reads and writes of the bitmap never share a cycle, so no forwarding is needed
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("bitmap read and write in the same cycle");

   // no transaction is taken in the first cycle after reset: clearing pass runs
   a_clear_after_reset: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> req_stall)
      else $error("request accepted before bitmap clear finished");

   // only a successful find carries a cluster number
   a_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status != ST_OK) |-> (rsp_data_ff.found_cluster == '0))
      else $error("non-ok transaction carries a cluster number");

   // a found cluster lies inside the configured limit
   a_found_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.found_cluster != '0) |->
      (rsp_data_ff.found_cluster <= eff_limit))
      else $error("found cluster beyond limit");

endmodule
